// File: sv/ben_pkg.sv
// Shared types and codes for the bully election node.
`default_nettype none
package ben_pkg;

    typedef enum logic [2:0] {
        FUNC_ELECTION      = 3'd0,
        FUNC_ELECTION_INIT = 3'd1,
        FUNC_ALIVE         = 3'd2,
        FUNC_TIME          = 3'd3,
        FUNC_COORDINATOR   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_ALIVE    = 2'd0,
        KIND_ELECTION = 2'd1,
        KIND_COORD    = 2'd2
    } msg_kind_t;

    typedef enum logic [1:0] {
        CFG_NODE_ID       = 2'd0,
        CFG_NEIGHBOR_MASK = 2'd1,
        CFG_CLAIM_WAIT    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ALIVE,
        SEQ_SCAN,
        SEQ_STATUS
    } seq_state_t;

    localparam int unsigned NODE_W     = 5;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned DELTA_W    = 16;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [DELTA_W-1:0] CLAIM_WAIT_RST = 16'd10;

    // Work handed from the protocol state to the fan-out sequencer
    typedef struct packed {
        logic              alive;
        logic [NODE_W-1:0] alive_dest;
        msg_kind_t         kind;
    } job_t;

endpackage
`default_nettype wire

// File: sv/ben_state.sv
// Configuration registers and election protocol state of the bully node.
`default_nettype none
module ben_state #(
    parameter int unsigned SCAN = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [ben_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            start,
    input  wire logic [2:0]                      func,
    input  wire logic [ben_pkg::NODE_W-1:0]      sender,
    input  wire logic [ben_pkg::TICK_W-1:0]      now_tick,
    output ben_pkg::job_t                        job,
    output logic [SCAN-1:0]                      elig,
    output logic [ben_pkg::NODE_W-1:0]           leader,
    output logic                                 leader_known
);

    logic [ben_pkg::NODE_W-1:0]  node_id_reg;
    logic [ben_pkg::MASK_W-1:0]  neighbor_mask_reg;
    logic [ben_pkg::DELTA_W-1:0] claim_wait_reg;

    logic                        started_reg, started_next;
    logic                        finished_reg, finished_next;
    logic [ben_pkg::TICK_W-1:0]  start_tick_reg, start_tick_next;
    logic [ben_pkg::NODE_W-1:0]  leader_reg, leader_next;
    logic                        leader_valid_reg, leader_valid_next;

    logic [SCAN-1:0] above_mask;
    logic [SCAN-1:0] all_mask;
    logic            deadline;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg       <= '0;
            neighbor_mask_reg <= '0;
            claim_wait_reg    <= ben_pkg::CLAIM_WAIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ben_pkg::CFG_NODE_ID:       node_id_reg <= cfg_wdata[ben_pkg::NODE_W-1:0];
                ben_pkg::CFG_NEIGHBOR_MASK: neighbor_mask_reg <= cfg_wdata;
                ben_pkg::CFG_CLAIM_WAIT:    claim_wait_reg <= cfg_wdata[ben_pkg::DELTA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int n = 0; n < int'(SCAN); n++) begin
            all_mask[n]   = neighbor_mask_reg[n];
            above_mask[n] = neighbor_mask_reg[n] && (n > int'(node_id_reg));
        end
    end

    assign deadline = {1'b0, now_tick} >=
                      ({1'b0, start_tick_reg} + (ben_pkg::TICK_W + 1)'(claim_wait_reg));

    always_comb begin
        started_next      = started_reg;
        finished_next     = finished_reg;
        start_tick_next   = start_tick_reg;
        leader_next       = leader_reg;
        leader_valid_next = leader_valid_reg;
        job.alive         = 1'b0;
        job.alive_dest    = sender;
        job.kind          = ben_pkg::KIND_ELECTION;
        elig              = '0;
        unique case (func)
            ben_pkg::FUNC_ELECTION, ben_pkg::FUNC_ELECTION_INIT: begin
                job.alive = (func == ben_pkg::FUNC_ELECTION);
                if (!started_reg) begin
                    started_next    = 1'b1;
                    start_tick_next = now_tick;
                    if (func == ben_pkg::FUNC_ELECTION_INIT || sender < node_id_reg) begin
                        elig = above_mask;
                    end
                end
            end
            ben_pkg::FUNC_ALIVE: begin
                finished_next = 1'b1;
            end
            ben_pkg::FUNC_TIME: begin
                if (started_reg && !finished_reg && deadline) begin
                    finished_next     = 1'b1;
                    elig              = all_mask;
                    job.kind          = ben_pkg::KIND_COORD;
                    leader_next       = node_id_reg;
                    leader_valid_next = 1'b1;
                end
            end
            ben_pkg::FUNC_COORDINATOR: begin
                leader_next       = sender;
                leader_valid_next = 1'b1;
                finished_next     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg      <= 1'b0;
            finished_reg     <= 1'b0;
            start_tick_reg   <= '0;
            leader_reg       <= '0;
            leader_valid_reg <= 1'b0;
        end else if (start) begin
            started_reg      <= started_next;
            finished_reg     <= finished_next;
            start_tick_reg   <= start_tick_next;
            leader_reg       <= leader_next;
            leader_valid_reg <= leader_valid_next;
        end
    end

    assign leader       = leader_reg;
    assign leader_known = leader_valid_reg;

endmodule
`default_nettype wire

// File: sv/ben_fanout.sv
// Fan-out sequencer: shifts the eligible vector one bit a cycle, waiting on a full output.
`default_nettype none
module ben_fanout #(
    parameter int unsigned SCAN = 32,
    parameter int unsigned IW   = 5
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  ben_pkg::job_t                   job,
    input  wire logic [SCAN-1:0]            elig,
    input  wire logic [ben_pkg::NODE_W-1:0] leader,
    input  wire logic                       leader_known,
    output logic                            ready,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            out_send,
    output logic [ben_pkg::NODE_W-1:0]      out_dest,
    output ben_pkg::msg_kind_t              out_kind,
    output logic [ben_pkg::NODE_W-1:0]      out_leader,
    output logic                            out_known,
    output logic                            out_last
);

    ben_pkg::seq_state_t            state_reg, state_next;
    logic [SCAN-1:0]                elig_reg, elig_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [ben_pkg::NODE_W-1:0]     alive_dest_reg, alive_dest_next;
    ben_pkg::msg_kind_t             kind_reg, kind_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_send_reg;
    logic [ben_pkg::NODE_W-1:0]     out_dest_reg;
    ben_pkg::msg_kind_t             out_kind_reg;
    logic [ben_pkg::NODE_W-1:0]     out_leader_reg;
    logic                           out_known_reg;
    logic                           out_last_reg;

    logic                           out_free;
    logic                           load;
    logic                           ld_send;
    logic [ben_pkg::NODE_W-1:0]     ld_dest;
    ben_pkg::msg_kind_t             ld_kind;
    logic                           ld_last;
    logic                           rest_empty;

    assign out_free   = !out_valid_reg || out_ready;
    assign rest_empty = ((elig_reg >> 1) == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ben_pkg::SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elig_reg       <= elig_next;
        idx_reg        <= idx_next;
        alive_dest_reg <= alive_dest_next;
        kind_reg       <= kind_next;
        if (load) begin
            out_send_reg   <= ld_send;
            out_dest_reg   <= ld_dest;
            out_kind_reg   <= ld_kind;
            out_leader_reg <= leader;
            out_known_reg  <= leader_known;
            out_last_reg   <= ld_last;
        end
    end

    always_comb begin
        state_next      = state_reg;
        elig_next       = elig_reg;
        idx_next        = idx_reg;
        alive_dest_next = alive_dest_reg;
        kind_next       = kind_reg;
        load            = 1'b0;
        ld_send         = 1'b1;
        ld_dest         = '0;
        ld_kind         = ben_pkg::KIND_ALIVE;
        ld_last         = 1'b1;
        unique case (state_reg)
            ben_pkg::SEQ_IDLE: begin
                if (start) begin
                    elig_next       = elig;
                    idx_next        = '0;
                    alive_dest_next = job.alive_dest;
                    kind_next       = job.kind;
                    if (job.alive) begin
                        state_next = ben_pkg::SEQ_ALIVE;
                    end else if (elig != '0) begin
                        state_next = ben_pkg::SEQ_SCAN;
                    end else begin
                        state_next = ben_pkg::SEQ_STATUS;
                    end
                end
            end
            ben_pkg::SEQ_ALIVE: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_dest    = alive_dest_reg;
                    ld_last    = (elig_reg == '0);
                    state_next = ld_last ? ben_pkg::SEQ_IDLE : ben_pkg::SEQ_SCAN;
                end
            end
            ben_pkg::SEQ_SCAN: begin
                if (!elig_reg[0]) begin
                    elig_next = elig_reg >> 1;
                    idx_next  = idx_reg + 1'b1;
                end else if (out_free) begin
                    load      = 1'b1;
                    ld_dest   = ben_pkg::NODE_W'(idx_reg);
                    ld_kind   = kind_reg;
                    ld_last   = rest_empty;
                    elig_next = elig_reg >> 1;
                    idx_next  = idx_reg + 1'b1;
                    if (rest_empty) begin
                        state_next = ben_pkg::SEQ_IDLE;
                    end
                end
            end
            ben_pkg::SEQ_STATUS: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_send    = 1'b0;
                    state_next = ben_pkg::SEQ_IDLE;
                end
            end
            default: state_next = ben_pkg::SEQ_IDLE;
        endcase
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign ready      = (state_reg == ben_pkg::SEQ_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_send   = out_send_reg;
    assign out_dest   = out_dest_reg;
    assign out_kind   = out_kind_reg;
    assign out_leader = out_leader_reg;
    assign out_known  = out_known_reg;
    assign out_last   = out_last_reg;

    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ben_pkg::SEQ_SCAN |-> elig_reg != '0)
        else $error("scan state with empty neighbour vector");

    a_status_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && state_reg == ben_pkg::SEQ_STATUS) |=> (out_last_reg && !out_send_reg))
        else $error("status beat not final or flagged as message");

    a_not_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_last_reg) |-> state_reg != ben_pkg::SEQ_IDLE)
        else $error("sequencer idle with more beats pending");

    a_scan_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && state_reg == ben_pkg::SEQ_SCAN) |=> (out_valid_reg && out_send_reg))
        else $error("status beat produced during a fan-out scan");

endmodule
`default_nettype wire

// File: sv/bully_election_node.sv
// Top level of one bully leader election node.
//
//  channel  | direction | beat carries
//  s_axis   | in        | func, sender, now_tick
//  m_axis   | out       | send_valid, dest, msg_kind, leader, leader_known; tlast = last
//  cfg      | in        | register write, no read-back
//
// A fan-out scans the neighbour vector one bit a cycle, min(NODES,32) nodes at most,
// after an Alive beat when the item asks for one; a beat giving no message yields one
// status beat. A stalled m_axis pauses the scan.
// aresetn is synchronous; config resets to node 0, no neighbours, wait of 10 ticks.
// s_axis_tready is low from an accepted beat until its final result is loaded.
`default_nettype none
module bully_election_node #(
    parameter int unsigned NODES = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [ben_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [39:0]                    s_axis_tdata,  // func, sender, now_tick
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // send_valid, dest, msg_kind, leader, leader_known, zero pad
    output logic [15:0]                         m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int unsigned SCAN = (NODES < 32) ? NODES : 32;
    localparam int unsigned IW   = (SCAN > 1) ? $clog2(SCAN) : 1;

    ben_pkg::job_t                  job;
    logic [SCAN-1:0]                elig;
    logic [ben_pkg::NODE_W-1:0]     leader;
    logic                           leader_known;
    logic                           start;
    logic                           out_send;
    logic [ben_pkg::NODE_W-1:0]     out_dest;
    ben_pkg::msg_kind_t             out_kind;
    logic [ben_pkg::NODE_W-1:0]     out_leader;
    logic                           out_known;

    assign start = s_axis_tvalid && s_axis_tready;

    ben_state #(
        .SCAN (SCAN)
    ) u_state (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .func         (s_axis_tdata[2:0]),
        .sender       (s_axis_tdata[7:3]),
        .now_tick     (s_axis_tdata[39:8]),
        .job          (job),
        .elig         (elig),
        .leader       (leader),
        .leader_known (leader_known)
    );

    ben_fanout #(
        .SCAN (SCAN),
        .IW   (IW)
    ) u_fanout (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .job          (job),
        .elig         (elig),
        .leader       (leader),
        .leader_known (leader_known),
        .ready        (s_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_send     (out_send),
        .out_dest     (out_dest),
        .out_kind     (out_kind),
        .out_leader   (out_leader),
        .out_known    (out_known),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_known, out_leader, out_kind, out_dest, out_send};

endmodule
`default_nettype wire

// File: dv/bully_election_node_test.sv
// Self-checking testbench for the bully election node: stream stimulus, scoreboard, watchdog.
`default_nettype none
module bully_election_node_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]                     FUNC_UNKNOWN_MIN = 3'd5;
    localparam logic [2:0]                     FUNC_UNKNOWN_MAX = 3'd7;
    localparam logic [ben_pkg::NODE_W-1:0]     NODE_MAX         = '1;
    localparam logic [ben_pkg::TICK_W-1:0]     TICK_MAX         = '1;
    localparam logic [ben_pkg::MASK_W-1:0]     MASK_ALL         = '1;
    localparam logic [ben_pkg::DELTA_W-1:0]    DELTA_MAX        = '1;
    localparam int unsigned                    IDLE_LIMIT       = 3000;
    localparam int unsigned                    LONG_HOLD        = 250;
    localparam int unsigned                    SETTLE_CYCLES    = 40;

    typedef struct packed {
        logic                       send_valid;
        logic [ben_pkg::NODE_W-1:0] dest;
        ben_pkg::msg_kind_t         kind;
        logic [ben_pkg::NODE_W-1:0] leader;
        logic                       leader_known;
        logic                       last;
    } reply_beat_t;

    class election_scoreboard;
        logic [ben_pkg::NODE_W-1:0]  node_id;
        logic [ben_pkg::MASK_W-1:0]  neighbor_mask;
        logic [ben_pkg::DELTA_W-1:0] claim_wait;
        bit                          started;
        bit                          finished;
        logic [ben_pkg::TICK_W-1:0]  start_tick;
        logic [ben_pkg::NODE_W-1:0]  leader_id;
        bit                          leader_valid;
        reply_beat_t                 replies_q[$];
        int unsigned                 mismatches, items, beats, claims, status_beats, cfg_writes;
        int unsigned                 kind_count[3];

        function new();
            node_id       = '0;
            neighbor_mask = '0;
            claim_wait    = ben_pkg::CLAIM_WAIT_RST;
            started       = 1'b0;
            finished      = 1'b0;
            start_tick    = '0;
            leader_id     = '0;
            leader_valid  = 1'b0;
        endfunction

        function void write_reg(ben_pkg::cfg_index_t idx,
                                logic [ben_pkg::CFG_DATA_W-1:0] value);
            cfg_writes++;
            case (idx)
                ben_pkg::CFG_NODE_ID:       node_id       = value[ben_pkg::NODE_W-1:0];
                ben_pkg::CFG_NEIGHBOR_MASK: neighbor_mask = value[ben_pkg::MASK_W-1:0];
                ben_pkg::CFG_CLAIM_WAIT:    claim_wait    = value[ben_pkg::DELTA_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted input beat and queue the replies it should produce
        function void note_input(logic [39:0] beat);
            logic [2:0]                 f;
            logic [ben_pkg::NODE_W-1:0] src;
            logic [ben_pkg::TICK_W-1:0] now;
            logic [ben_pkg::NODE_W-1:0] dests[$];
            ben_pkg::msg_kind_t         kinds[$];
            reply_beat_t                b;
            f   = beat[2:0];
            src = beat[7:3];
            now = beat[39:8];
            items++;
            if (f == ben_pkg::FUNC_ELECTION || f == ben_pkg::FUNC_ELECTION_INIT) begin
                if (f == ben_pkg::FUNC_ELECTION) begin
                    dests.push_back(src);
                    kinds.push_back(ben_pkg::KIND_ALIVE);
                end
                if (!started) begin
                    started    = 1'b1;
                    start_tick = now;
                    if (f == ben_pkg::FUNC_ELECTION_INIT || src < node_id) begin
                        for (int n = int'(node_id) + 1; n < 32; n++) begin
                            if (neighbor_mask[n]) begin
                                dests.push_back(ben_pkg::NODE_W'(n));
                                kinds.push_back(ben_pkg::KIND_ELECTION);
                            end
                        end
                    end
                end
            end else if (f == ben_pkg::FUNC_ALIVE) begin
                finished = 1'b1;
            end else if (f == ben_pkg::FUNC_TIME) begin
                // deadline sum kept at 33 bits, no wrap
                if (started && !finished &&
                    {1'b0, now} >= {1'b0, start_tick} + {17'b0, claim_wait}) begin
                    finished = 1'b1;
                    for (int n = 0; n < 32; n++) begin
                        if (neighbor_mask[n]) begin
                            dests.push_back(ben_pkg::NODE_W'(n));
                            kinds.push_back(ben_pkg::KIND_COORD);
                        end
                    end
                    leader_id    = node_id;
                    leader_valid = 1'b1;
                    claims++;
                end
            end else if (f == ben_pkg::FUNC_COORDINATOR) begin
                leader_id    = src;
                leader_valid = 1'b1;
                finished     = 1'b1;
            end

            if (dests.size() == 0) begin
                b = '{send_valid: 1'b0, dest: '0, kind: ben_pkg::KIND_ALIVE, leader: leader_id,
                      leader_known: leader_valid, last: 1'b1};
                replies_q.push_back(b);
            end else begin
                foreach (dests[k]) begin
                    b = '{send_valid: 1'b1, dest: dests[k], kind: kinds[k], leader: leader_id,
                          leader_known: leader_valid, last: (k == dests.size() - 1)};
                    replies_q.push_back(b);
                end
            end
        endfunction

        function void check_result(logic [15:0] data, logic last);
            reply_beat_t got, want;
            got.send_valid   = data[0];
            got.dest         = data[5:1];
            got.kind         = ben_pkg::msg_kind_t'(data[7:6]);
            got.leader       = data[12:8];
            got.leader_known = data[13];
            got.last         = last;
            beats++;
            if (replies_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat data=%h last=%b", $realtime, data, last);
                return;
            end
            want = replies_q.pop_front();
            if (got !== want || data[15:14] !== 2'b00) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: beat %0d expected v=%b d=%0d k=%0d ldr=%0d kn=%b last=%b",
                             $realtime, beats, want.send_valid, want.dest, want.kind,
                             want.leader, want.leader_known, want.last);
                    $display("%0t: beat %0d got v=%b d=%0d k=%0d ldr=%0d kn=%b last=%b pad=%b",
                             $realtime, beats, got.send_valid, got.dest, got.kind,
                             got.leader, got.leader_known, got.last, data[15:14]);
                end
            end else if (!want.send_valid) begin
                status_beats++;
            end else begin
                kind_count[want.kind]++;
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [1:0]                     cfg_index;
    logic [ben_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [39:0]                    s_axis_tdata;   // func, sender, now_tick
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // send_valid, dest, msg_kind, leader, leader_known, pad
    logic [15:0]                    m_axis_tdata;
    logic                           m_axis_tlast;

    election_scoreboard sb = new();
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;
    int unsigned        rx_hold_left = 0;
    int unsigned        quiet_cycles = 0;

    bully_election_node dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("bully_election_node_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        int unsigned stall_left, run_left;
        stall_left    = 0;
        run_left      = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_axis_tready = 1'b0;
                rx_hold_left--;
            end else if (!rx_idle_on) begin
                m_axis_tready = 1'b1;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    if ($urandom_range(0, 2) == 0)
                        stall_left = $urandom_range(1, 18);
                    else
                        run_left = $urandom_range(1, 40);
                end
                if (stall_left > 0) begin
                    m_axis_tready = 1'b0;
                    stall_left--;
                end else begin
                    m_axis_tready = 1'b1;
                    run_left--;
                end
            end
        end
    end

    task automatic send_item(input logic [2:0] f, input logic [ben_pkg::NODE_W-1:0] src,
                             input logic [ben_pkg::TICK_W-1:0] tick);
        int unsigned gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {8'($urandom), $urandom};
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  = {tick, src, f};
        s_axis_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.replies_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input ben_pkg::cfg_index_t idx,
                             input logic [ben_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_random(input int unsigned count);
        logic [2:0] f;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: f = ben_pkg::FUNC_ELECTION;
                4:          f = ben_pkg::FUNC_ELECTION_INIT;
                5:          f = ben_pkg::FUNC_ALIVE;
                6:          f = ben_pkg::FUNC_TIME;
                7, 8:       f = ben_pkg::FUNC_COORDINATOR;
                default:    f = 3'($urandom_range(FUNC_UNKNOWN_MIN, FUNC_UNKNOWN_MAX));
            endcase
            send_item(f, ben_pkg::NODE_W'($urandom_range(0, NODE_MAX)), $urandom);
        end
    endtask

    initial begin
        logic [ben_pkg::NODE_W-1:0] me;
        logic [ben_pkg::TICK_W-1:0] start_at;
        int unsigned                finish_way;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = ben_pkg::CFG_NODE_ID;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        me = ben_pkg::NODE_W'($urandom_range(1, 30));
        write_reg(ben_pkg::CFG_NODE_ID, ben_pkg::CFG_DATA_W'(me));
        write_reg(ben_pkg::CFG_NEIGHBOR_MASK, MASK_ALL);
        write_reg(ben_pkg::CFG_CLAIM_WAIT, ben_pkg::CFG_DATA_W'(DELTA_MAX));

        for (int u = FUNC_UNKNOWN_MIN; u <= FUNC_UNKNOWN_MAX; u++)
            send_item(3'(u), u[0] ? NODE_MAX : '0, u[0] ? '0 : TICK_MAX);
        send_item(ben_pkg::FUNC_TIME, '0, TICK_MAX);    // not started yet

        // start tick near the top so the deadline only fits in 33 bits
        start_at = TICK_MAX - ben_pkg::TICK_W'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
            0:       send_item(ben_pkg::FUNC_ELECTION_INIT, NODE_MAX, start_at);
            1:       send_item(ben_pkg::FUNC_ELECTION, '0, start_at);
            default: send_item(ben_pkg::FUNC_ELECTION, NODE_MAX, start_at);
        endcase
        send_item(ben_pkg::FUNC_ELECTION, me, '0);
        send_item(ben_pkg::FUNC_ELECTION_INIT, '0, '0);
        send_item(ben_pkg::FUNC_TIME, NODE_MAX, TICK_MAX);
        wait_drained();

        write_reg(ben_pkg::CFG_CLAIM_WAIT, '0);
        send_item(ben_pkg::FUNC_TIME, '0, start_at - 1);
        rx_hold_left = LONG_HOLD;
        finish_way   = $urandom_range(0, 3);
        if (finish_way == 1)
            send_item(ben_pkg::FUNC_ALIVE, me, start_at);
        else if (finish_way == 2)
            send_item(ben_pkg::FUNC_COORDINATOR, NODE_MAX, start_at);
        send_item(ben_pkg::FUNC_TIME, NODE_MAX, start_at);
        send_item(ben_pkg::FUNC_COORDINATOR, '0, TICK_MAX);
        send_item(ben_pkg::FUNC_ALIVE, NODE_MAX, '0);
        send_item(ben_pkg::FUNC_ELECTION, NODE_MAX, $urandom);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(ben_pkg::CFG_NODE_ID, '0);
                    write_reg(ben_pkg::CFG_NEIGHBOR_MASK, '0);
                    write_reg(ben_pkg::CFG_CLAIM_WAIT, '0);
                end
                1: begin
                    write_reg(ben_pkg::CFG_NODE_ID, ben_pkg::CFG_DATA_W'(NODE_MAX));
                    write_reg(ben_pkg::CFG_NEIGHBOR_MASK, MASK_ALL);
                    write_reg(ben_pkg::CFG_CLAIM_WAIT, ben_pkg::CFG_DATA_W'(DELTA_MAX));
                end
                default: begin
                    write_reg(ben_pkg::CFG_NODE_ID,
                              ben_pkg::CFG_DATA_W'($urandom_range(0, NODE_MAX)));
                    write_reg(ben_pkg::CFG_NEIGHBOR_MASK, $urandom);
                    write_reg(ben_pkg::CFG_CLAIM_WAIT,
                              ben_pkg::CFG_DATA_W'($urandom_range(0, DELTA_MAX)));
                end
            endcase
            if (ph == 3) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            send_random(60);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("covered %0d items, %0d beats: %0d alive, %0d election, %0d coord, %0d status",
                 sb.items, sb.beats, sb.kind_count[ben_pkg::KIND_ALIVE],
                 sb.kind_count[ben_pkg::KIND_ELECTION], sb.kind_count[ben_pkg::KIND_COORD],
                 sb.status_beats);
        $display("leader claims %0d, final leader %0d known=%b, %0d reg writes, %0d mismatches",
                 sb.claims, sb.leader_id, sb.leader_valid, sb.cfg_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.replies_q.size() == 0)
            $display("bully_election_node_test: PASS");
        else
            $display("bully_election_node_test: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
sv/ben_pkg.sv
sv/ben_state.sv
sv/ben_fanout.sv
sv/bully_election_node.sv
dv/bully_election_node_test.sv
